// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the geodesic dilation RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/gdil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdil_pkg
// Types and constants of the 3x3 geodesic dilation block.
// ----------------------------------------------------------------------------
package gdil_pkg;

    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int ROWS_REG_BITS = 11;
    localparam int COLS_REG_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [ROWS_REG_BITS-1:0] ROWS_RESET = 11'd1024;
    localparam logic [COLS_REG_BITS-1:0] COLS_RESET = 16'd3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1,
        CFG_MASK = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic has_result;
        logic last;
    } t_stage_ctl;

endpackage

// File: src/geodesic_dilate_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodesic_dilate_3x3
// Streaming 3x3 geodesic dilation of a padded image in column-major order.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                  Payload
//  s_axis   in   s_axis_tvalid/tready       tdata: marker, bound; tuser: flag
//  m_axis   out  m_axis_tvalid/tready       tdata: result; tuser: activity;
//                                           tlast: last interior pixel
//  cfg      in   i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
//  One pixel is accepted per cycle while the input is not stalled. A result is
//  registered in the read stage, with the registered memory read, then in the output register.
//  Reset clears the positions, configuration registers and valid flags; the column memories
//  are not cleared because every column is rewritten before the window uses it.
//  The input stalls only while the output register holds an untaken result
//  and the read stage also holds a result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module geodesic_dilate_3x3 #(
    parameter int MAX_ROWS   = gdil_pkg::DEF_MAX_ROWS,
    parameter int PIXEL_BITS = gdil_pkg::DEF_PIXEL_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: marker_pixel, bound_pixel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // tuser: process_flag
    input  logic                                s_axis_tuser,
    // tdata: result_pixel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // tuser: activity
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gdil_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [gdil_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int RW = (AW + 1 > gdil_pkg::ROWS_REG_BITS) ? AW + 1 : gdil_pkg::ROWS_REG_BITS;
    localparam int CB = gdil_pkg::COLS_REG_BITS;
    localparam int OUT_TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;

    logic [gdil_pkg::ROWS_REG_BITS-1:0] r_rows_in_use;
    logic [CB-1:0]                      r_cols_in_use;
    logic                               r_mask_en;
    logic [AW-1:0]                      r_row;
    logic [CB-1:0]                      r_col;
    logic [AW-1:0]                      n_row;
    logic [CB-1:0]                      n_col;

    logic                  r_s1_v;
    gdil_pkg::t_stage_ctl  r_s1;
    logic [PIXEL_BITS-1:0] r_s1_mk;
    logic [AW-1:0]         r_s1_row;

    logic [PIXEL_BITS-1:0] r_rmax0;
    logic [PIXEL_BITS-1:0] r_rmax1;
    logic [PIXEL_BITS-1:0] r_ctr_m;
    logic [PIXEL_BITS-1:0] r_held_bound;
    logic                  r_held_flag;

    logic                  r_out_v;
    logic [PIXEL_BITS-1:0] r_out_result;
    logic                  r_out_act;
    logic                  r_out_last;

    logic [PIXEL_BITS-1:0] in_mk;
    logic [PIXEL_BITS-1:0] in_bd;
    logic                  in_acc;
    logic                  cfg_acc;
    logic                  cfg_pos_clr;
    logic [RW-1:0]         rows_ext;
    logic [RW-1:0]         rows_eff;
    logic [RW-1:0]         last_row;
    logic [CB-1:0]         last_col;
    logic                  row_last;
    logic                  col_last;
    logic                  acc_last;

    logic [2*PIXEL_BITS-1:0] rd_mk;
    logic [PIXEL_BITS:0]   rd_ctr;
    logic [PIXEL_BITS-1:0] prev_col_mk;
    logic [PIXEL_BITS-1:0] old_col_mk;
    logic [PIXEL_BITS-1:0] max01;
    logic [PIXEL_BITS-1:0] new_max;
    logic [PIXEL_BITS-1:0] old_max;
    logic [PIXEL_BITS-1:0] wmax;
    logic [PIXEL_BITS-1:0] n_result;
    logic                  n_act;
    logic                  s1_go;

    assign in_mk   = s_axis_tdata[PIXEL_BITS-1:0];
    assign in_bd   = s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign cfg_pos_clr = cfg_acc && ((i_cfg_index == gdil_pkg::CFG_ROWS) ||
                                     (i_cfg_index == gdil_pkg::CFG_COLS));

    always_comb begin
        rows_ext = RW'(r_rows_in_use);
        priority if (rows_ext < RW'(3)) begin
            rows_eff = RW'(3);
        end else if (rows_ext > RW'(MAX_ROWS)) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
        last_row = rows_eff - RW'(1);
        last_col = (r_cols_in_use < CB'(3)) ? CB'(2) : r_cols_in_use - CB'(1);
        row_last = RW'(r_row) >= last_row;
        col_last = r_col >= last_col;
        acc_last = row_last && col_last;
        if (row_last) begin
            n_row = '0;
            n_col = col_last ? '0 : r_col + CB'(1);
        end else begin
            n_row = r_row + AW'(1);
            n_col = r_col;
        end
    end

    // Each word holds the markers of the two latest columns at one row, the
    // newer one in the upper half; it is written back from the read stage.
    gdil_ram #(.WIDTH(2 * PIXEL_BITS), .DEPTH(MAX_ROWS)) u_markers (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_row),
        .i_wr_data ({r_s1_mk, prev_col_mk}),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_row),
        .o_rd_data (rd_mk)
    );

    gdil_ram #(.WIDTH(PIXEL_BITS + 1), .DEPTH(MAX_ROWS)) u_centre (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_row),
        .i_wr_data ({s_axis_tuser, in_bd}),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_row),
        .o_rd_data (rd_ctr)
    );

    always_comb begin
        prev_col_mk = rd_mk[2*PIXEL_BITS-1:PIXEL_BITS];
        old_col_mk  = rd_mk[PIXEL_BITS-1:0];
        max01   = (prev_col_mk > old_col_mk) ? prev_col_mk : old_col_mk;
        new_max = (max01 > r_s1_mk) ? max01 : r_s1_mk;
        old_max = (r_rmax0 > r_rmax1) ? r_rmax0 : r_rmax1;
        wmax    = (new_max > old_max) ? new_max : old_max;
        n_act   = 1'b0;
        priority if (r_mask_en && !r_held_flag) begin
            n_result = r_ctr_m;
        end else if (r_held_bound > r_ctr_m) begin
            n_result = (wmax < r_held_bound) ? wmax : r_held_bound;
            n_act    = n_result != r_ctr_m;
        end else begin
            n_result = r_held_bound;
        end
    end

    assign s1_go = r_s1_v && (!r_s1.has_result || !r_out_v || m_axis_tready);
    assign s_axis_tready = !r_s1_v || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= gdil_pkg::ROWS_RESET;
            r_cols_in_use <= gdil_pkg::COLS_RESET;
            r_mask_en     <= 1'b0;
            r_row         <= '0;
            r_col         <= '0;
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    gdil_pkg::CFG_ROWS: begin
                        r_rows_in_use <= i_cfg_data[gdil_pkg::ROWS_REG_BITS-1:0];
                    end
                    gdil_pkg::CFG_COLS: begin
                        r_cols_in_use <= i_cfg_data[CB-1:0];
                    end
                    gdil_pkg::CFG_MASK: begin
                        r_mask_en <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (cfg_pos_clr) begin
                r_row <= '0;
                r_col <= '0;
            end else if (in_acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go && r_s1.has_result) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.has_result <= (r_row >= AW'(2)) && (r_col >= CB'(2));
            r_s1.last       <= acc_last;
            r_s1_mk         <= in_mk;
            r_s1_row        <= r_row;
        end
        if (s1_go) begin
            r_rmax0      <= r_rmax1;
            r_rmax1      <= new_max;
            r_ctr_m      <= prev_col_mk;
            r_held_bound <= rd_ctr[PIXEL_BITS-1:0];
            r_held_flag  <= rd_ctr[PIXEL_BITS];
        end
        if (s1_go && r_s1.has_result) begin
            r_out_result <= n_result;
            r_out_act    <= n_act;
            r_out_last   <= r_s1.last;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_result);
    assign m_axis_tuser  = r_out_act;
    assign m_axis_tlast  = r_out_last;

    `ASSERT_IMP(a_row_in_range, i_clk, i_rst_n, 1'b1, RW'(r_row) <= last_row, "row position past image height")
    `ASSERT_NEXT(a_wrap_after_last, i_clk, i_rst_n, in_acc && acc_last && !cfg_pos_clr, (r_row == '0) && (r_col == '0), "position did not wrap after last pixel")
    `ASSERT_IMP(a_act_bounded, i_clk, i_rst_n, s1_go && r_s1.has_result && n_act, (n_result > r_ctr_m) && (n_result <= r_held_bound), "activity without upward bounded change")
    `ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, r_out_v && !m_axis_tready && r_s1_v && r_s1.has_result, !s_axis_tready, "input taken while both result slots are full")

endmodule

// File: src/gdil_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdil_ram
// Simple dual-port RAM with one write port and one registered read port.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module gdil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: bench/geodesic_dilate_3x3_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodesic_dilate_3x3_test
// Self-checking bench for the streaming 3x3 geodesic dilation block. A short
// table of directed images is followed by fixed and randomized image phases with
// size and mask changes between them. Every accepted pixel is run through a
// local model of the dilation window, and each output transaction is compared
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module geodesic_dilate_3x3_test;

    localparam logic [gdil_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int MAX_R = gdil_pkg::DEF_MAX_ROWS;

    typedef struct packed {
        logic [7:0] value;
        logic       active;
        logic       last;
    } t_dil_result;

    typedef struct {
        bit                                  is_cfg;
        logic [gdil_pkg::CFG_IDX_BITS-1:0]   idx;
        logic [gdil_pkg::CFG_DATA_BITS-1:0]  data;
        logic [7:0]                          marker;
        logic [7:0]                          bound;
        logic                                flag;
        bit                                  typed;
        t_dil_result                         want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [gdil_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [gdil_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;

    geodesic_dilate_3x3 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Local copy of the block state.
    logic [10:0] cfg_rows;
    logic [15:0] cfg_cols;
    logic        cfg_mask;
    logic [7:0]  marker_cols [2*MAX_R];
    logic [7:0]  centre_bounds [MAX_R];
    logic        centre_flags [MAX_R];
    logic [7:0]  win [3][3];
    int unsigned row_pos;
    int unsigned col_pos;
    logic [7:0]  held_bound;
    logic        held_flag;

    t_dil_result pending_dilations[$];
    t_stim_row   stim_table[$];
    t_dil_result got_expect;
    int          mismatch_count = 0;
    int          hold_left = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;
    bit          calm = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic int unsigned eff_rows(input logic [10:0] v);
        if (v < 3) return 3;
        if (v > MAX_R) return MAX_R;
        return 32'(v);
    endfunction

    function automatic int unsigned eff_cols(input logic [15:0] v);
        return (v < 3) ? 3 : 32'(v);
    endfunction

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic apply_register(input logic [gdil_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [gdil_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            gdil_pkg::CFG_ROWS: begin
                cfg_rows = data[10:0];
                row_pos = 0;
                col_pos = 0;
            end
            gdil_pkg::CFG_COLS: begin
                cfg_cols = data;
                row_pos = 0;
                col_pos = 0;
            end
            gdil_pkg::CFG_MASK: cfg_mask = data[0];
            default: ;
        endcase
    endtask

    task automatic dilate_step(input logic [7:0] marker, input logic [7:0] bound,
                               input logic flag, output bit produced,
                               output t_dil_result res);
        int unsigned rows, cols, r, c, old_base, prev_base;
        logic [7:0]  cb, cm, wmax;
        logic        cf;
        rows = eff_rows(cfg_rows);
        cols = eff_cols(cfg_cols);
        r = row_pos;
        c = col_pos;
        old_base = (c & 1) * MAX_R;
        prev_base = ((c + 1) & 1) * MAX_R;
        for (int a = 0; a < 2; a++)
            for (int b = 0; b < 3; b++)
                win[a][b] = win[a+1][b];
        win[2][0] = marker_cols[old_base + r];
        win[2][1] = marker_cols[prev_base + r];
        win[2][2] = marker;
        marker_cols[old_base + r] = marker;
        cb = held_bound;
        cf = held_flag;
        held_bound = centre_bounds[r];
        held_flag = centre_flags[r];
        centre_bounds[r] = bound;
        centre_flags[r] = flag;
        produced = 0;
        res = '0;
        if (r >= 2 && c >= 2) begin
            cm = win[1][1];
            wmax = 8'd0;
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    if (win[a][b] > wmax) wmax = win[a][b];
            if (cfg_mask && !cf) begin
                res.value = cm;
            end else if (cb > cm) begin
                res.value = (wmax < cb) ? wmax : cb;
                res.active = (res.value != cm);
            end else begin
                res.value = cb;
            end
            res.last = (r >= rows - 1) && (c >= cols - 1);
            produced = 1;
        end
        if (r >= rows - 1) begin
            row_pos = 0;
            col_pos = (c >= cols - 1) ? 0 : ((c + 1) & 16'hFFFF);
        end else begin
            row_pos = r + 1;
        end
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_dilations.size() != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_dilations.size() != 0) begin
            report_mismatch("results never delivered", 0, pending_dilations.size());
            pending_dilations.delete();
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [gdil_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [gdil_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [7:0] marker, input logic [7:0] bound,
                              input logic flag, input bit typed, input t_dil_result want);
        bit          produced;
        t_dil_result predicted;
        while (!calm && $urandom_range(0, 99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {bound, marker};
        s_axis_tuser <= flag;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        dilate_step(marker, bound, flag, produced, predicted);
        if (produced) pending_dilations.push_back(typed ? want : predicted);
    endtask

    task automatic add_row(input bit is_cfg, input logic [gdil_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [gdil_pkg::CFG_DATA_BITS-1:0] data,
                           input logic [7:0] marker,
                           input logic [7:0] bound, input logic flag, input bit typed,
                           input t_dil_result want);
        t_stim_row row;
        row.is_cfg = is_cfg;
        row.idx = idx;
        row.data = data;
        row.marker = marker;
        row.bound = bound;
        row.flag = flag;
        row.typed = typed;
        row.want = want;
        stim_table.push_back(row);
    endtask

    task automatic run_phase(input bit w_rows, input logic [10:0] rows,
                             input bit w_cols, input logic [15:0] cols,
                             input bit w_mask, input logic mask, input int count);
        logic [15:0] junk;
        junk = 16'($urandom);
        if (w_rows || w_cols || w_mask) settle();
        if (w_rows) write_reg(gdil_pkg::CFG_ROWS, {junk[15:11], rows});
        if (w_cols) write_reg(gdil_pkg::CFG_COLS, cols);
        if (w_mask) write_reg(gdil_pkg::CFG_MASK, {junk[15:1], mask});
        for (int k = 0; k < count; k++)
            send_pixel(pick_pixel(), pick_pixel(), 1'($urandom_range(0, 1)), 0, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_dilations.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, -1);
            end else begin
                got_expect = pending_dilations.pop_front();
                if (m_axis_tdata !== got_expect.value)
                    report_mismatch("result pixel", m_axis_tdata, got_expect.value);
                if (m_axis_tuser !== got_expect.active)
                    report_mismatch("activity", m_axis_tuser, got_expect.active);
                if (m_axis_tlast !== got_expect.last)
                    report_mismatch("last pixel", m_axis_tlast, got_expect.last);
            end
        end
    end

    // Output side: random backpressure, or always ready while calm, plus one long hold when requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!hold_done && hold_req) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 18);
            end
        end
    end

    initial begin
        bit          prev_cfg;
        int          rand_items;
        int          size, count;
        logic [10:0] rv;
        logic [15:0] cv;
        cfg_rows = gdil_pkg::ROWS_RESET;
        cfg_cols = gdil_pkg::COLS_RESET;
        cfg_mask = 1'b0;
        for (int k = 0; k < 2*MAX_R; k++) marker_cols[k] = 8'd0;
        for (int k = 0; k < MAX_R; k++) begin
            centre_bounds[k] = 8'd0;
            centre_flags[k] = 1'b0;
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                win[a][b] = 8'd0;
        row_pos = 0;
        col_pos = 0;
        held_bound = 8'd0;
        held_flag = 1'b0;

        // A row write of zero gives the smallest image; the column count keeps its
        // reset value and the mask is still off, so clear flags are ignored.
        add_row(1, gdil_pkg::CFG_ROWS, 16'd0, 0, 0, 0, 0, '0);
        for (int k = 0; k < 9; k++)
            add_row(0, gdil_pkg::CFG_ROWS, 0, (k == 0) ? 8'd200 : 8'd0, 8'd255, 1'b0, k == 8,
                    '{value: 8'd200, active: 1'b1, last: 1'b1});
        // A masked centre passes through unchanged.
        add_row(1, gdil_pkg::CFG_COLS, 16'd0, 0, 0, 0, 0, '0);
        add_row(1, gdil_pkg::CFG_MASK, 16'd1, 0, 0, 0, 0, '0);
        for (int k = 0; k < 9; k++)
            add_row(0, gdil_pkg::CFG_ROWS, 0, (k == 4) ? 8'd0 : 8'd255, 8'd255, k != 4, k == 8,
                    '{value: 8'd0, active: 1'b0, last: 1'b1});
        // A write to an unknown index leaves the size as it was.
        add_row(1, CFG_UNUSED, 16'hFFFF, 0, 0, 0, 0, '0);
        for (int k = 0; k < 9; k++)
            add_row(0, gdil_pkg::CFG_ROWS, 0, 8'd255, 8'd0, 1'b1, k == 8,
                    '{value: 8'd0, active: 1'b0, last: 1'b1});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prev_cfg = 0;
        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg) begin
                if (!prev_cfg) settle();
                write_reg(stim_table[i].idx, stim_table[i].data);
            end else begin
                send_pixel(stim_table[i].marker, stim_table[i].bound, stim_table[i].flag,
                           stim_table[i].typed, stim_table[i].want);
            end
            prev_cfg = stim_table[i].is_cfg;
        end

        // Full image with no idling on either side.
        calm = 1;
        run_phase(1, 11'd10, 1, 16'd12, 1, 1'b0, 120);
        calm = 0;
        // Oversized row count; the next size write restarts the image.
        run_phase(1, 11'h7FF, 1, 16'd4, 1, 1'b1, 40);
        // Widest image with the output held off for a long stretch, then a mask
        // change in the middle of it.
        hold_req = 1;
        run_phase(1, 11'd3, 1, 16'hFFFF, 0, 1'b0, 60);
        run_phase(0, 11'd0, 0, 16'd0, 1, 1'b0, 30);

        rand_items = 0;
        while (rand_items < 250) begin
            rv = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2))
                                             : 11'($urandom_range(3, 12));
            cv = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                             : 16'($urandom_range(3, 8));
            size = int'(eff_rows(rv) * eff_cols(cv));
            case ($urandom_range(0, 3))
                0: count = int'($urandom_range(1, 2 * size));
                1: count = 2 * size;
                default: count = size;
            endcase
            run_phase($urandom_range(0, 3) != 0, rv, $urandom_range(0, 3) != 0, cv,
                      $urandom_range(0, 1) == 1, 1'($urandom_range(0, 1)), count);
            rand_items += count;
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
